// ----- hdl/cpu8ex_pkg.sv -----
package cpu8ex_pkg;

  // Mnemonic index as carried by the input word, alphabetical order.
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_BIT = 6'd2,  OP_CLC = 6'd3,
    OP_CLD = 6'd4,  OP_CLI = 6'd5,  OP_CLV = 6'd6,  OP_CMP = 6'd7,
    OP_CPX = 6'd8,  OP_CPY = 6'd9,  OP_DEC = 6'd10, OP_DEX = 6'd11,
    OP_DEY = 6'd12, OP_EOR = 6'd13, OP_INC = 6'd14, OP_INX = 6'd15,
    OP_INY = 6'd16, OP_LDA = 6'd17, OP_LDX = 6'd18, OP_LDY = 6'd19,
    OP_NOP = 6'd20, OP_ORA = 6'd21, OP_PHA = 6'd22, OP_PHP = 6'd23,
    OP_PLA = 6'd24, OP_PLP = 6'd25, OP_SBC = 6'd26, OP_SEC = 6'd27,
    OP_SED = 6'd28, OP_SEI = 6'd29, OP_STA = 6'd30, OP_STX = 6'd31,
    OP_STY = 6'd32, OP_TAX = 6'd33, OP_TAY = 6'd34, OP_TSX = 6'd35,
    OP_TXA = 6'd36, OP_TXS = 6'd37, OP_TYA = 6'd38
  } op_e;

  // Status bit positions in NV1BDIZC.
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] FLAGS_RESET = 8'h24;
  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] STACK_PAGE  = 8'h01;
  localparam logic [7:0] PUSH_BITS   = 8'h30;
  localparam logic [7:0] PULL_MASK   = 8'hCF;
  localparam logic [7:0] UNUSED_BIT  = 8'h20;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 64;
  localparam int unsigned USER_W = 2;

  // Instruction queue between the decoder and the execute stage.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One decoded instruction.
  typedef struct packed {
    op_e         op;
    logic        mem_wr;
    logic        stack_pull;
    logic [7:0]  operand;
    logic [15:0] address;
  } dec_t;

endpackage

// ----- hdl/cpu8ex_front.sv -----
module cpu8ex_front (
  input  logic [cpu8ex_pkg::IN_W-1:0] tdata_i,
  output cpu8ex_pkg::dec_t            dec_o
);
  import cpu8ex_pkg::*;

  logic [5:0] opcode;

  assign opcode = tdata_i[5:0];

  always_comb begin
    dec_o.operand = tdata_i[13:6];
    dec_o.address = tdata_i[29:14];
    // Codes past the end of the mnemonic list behave as NOP.
    if (opcode > OP_TYA) begin
      dec_o.op = OP_NOP;
    end else begin
      dec_o.op = op_e'(opcode);
    end
    dec_o.mem_wr     = dec_o.op inside {OP_STA, OP_STX, OP_STY, OP_INC, OP_DEC,
                                        OP_PHA, OP_PHP};
    dec_o.stack_pull = dec_o.op inside {OP_PLA, OP_PLP};
  end

endmodule

// ----- hdl/cpu8ex_fifo.sv -----
module cpu8ex_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpu8ex_pkg::dec_t push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output cpu8ex_pkg::dec_t head_o,
  output logic             head_valid_o
);
  import cpu8ex_pkg::*;

  dec_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/cpu8ex_back.sv -----
module cpu8ex_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpu8ex_pkg::dec_t              head_i,
  input  logic                          head_valid_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [cpu8ex_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic [cpu8ex_pkg::USER_W-1:0] m_axis_tuser_o
);
  import cpu8ex_pkg::*;

  logic [7:0] a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, f_q, f_d;
  logic       pend_vld_q, pend_vld_d, pend_val_q, pend_val_d;
  logic       out_vld_q;
  logic [OUT_W-1:0]  out_data_q;
  logic [USER_W-1:0] out_user_q;

  logic [7:0]  m, m_eff, nz_val, sum_r;
  logic [8:0]  sum, diff;
  logic        nz_en;
  logic [15:0] maddr;
  logic [7:0]  mdata;
  logic        fire;

  // Execute whenever the output register is empty or is being emptied.
  assign fire  = head_valid_i && (!out_vld_q || m_axis_tready_i);
  assign pop_o = fire;

  assign m       = head_i.operand;
  assign m_eff   = (head_i.op == OP_SBC) ? ~m : m;

  always_comb begin
    f_d        = f_q;
    // A pending interrupt-disable change lands before the instruction runs.
    if (pend_vld_q) begin
      f_d[FlagI] = pend_val_q;
    end
    a_d        = a_q;
    x_d        = x_q;
    y_d        = y_q;
    sp_d       = sp_q;
    pend_vld_d = 1'b0;
    pend_val_d = pend_val_q;
    nz_en      = 1'b0;
    nz_val     = '0;
    maddr      = '0;
    mdata      = '0;
    sum        = {1'b0, a_q} + {1'b0, m_eff} + {8'h00, f_d[FlagC]};
    sum_r      = sum[7:0];
    diff       = '0;
    case (head_i.op)
      OP_ADC, OP_SBC: begin
        a_d        = sum_r;
        f_d[FlagC] = sum[8];
        f_d[FlagV] = ((a_q ^ sum_r) & (m_eff ^ sum_r)) >> 7 != 8'h00;
        nz_en      = 1'b1;
        nz_val     = sum_r;
      end
      OP_AND: begin
        a_d = a_q & m; nz_en = 1'b1; nz_val = a_q & m;
      end
      OP_ORA: begin
        a_d = a_q | m; nz_en = 1'b1; nz_val = a_q | m;
      end
      OP_EOR: begin
        a_d = a_q ^ m; nz_en = 1'b1; nz_val = a_q ^ m;
      end
      OP_BIT: begin
        f_d[FlagZ] = (a_q & m) == 8'h00;
        f_d[FlagV] = m[6];
        f_d[FlagN] = m[7];
      end
      OP_CLC: f_d[FlagC] = 1'b0;
      OP_SEC: f_d[FlagC] = 1'b1;
      OP_CLD: f_d[FlagD] = 1'b0;
      OP_SED: f_d[FlagD] = 1'b1;
      OP_CLV: f_d[FlagV] = 1'b0;
      OP_CLI: begin
        pend_vld_d = 1'b1; pend_val_d = 1'b0;
      end
      OP_SEI: begin
        pend_vld_d = 1'b1; pend_val_d = 1'b1;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        if (head_i.op == OP_CMP) begin
          diff = {1'b0, a_q} - {1'b0, m};
        end else if (head_i.op == OP_CPX) begin
          diff = {1'b0, x_q} - {1'b0, m};
        end else begin
          diff = {1'b0, y_q} - {1'b0, m};
        end
        f_d[FlagC] = !diff[8];
        nz_en      = 1'b1;
        nz_val     = diff[7:0];
      end
      OP_DEC: begin
        nz_en = 1'b1; nz_val = m - 8'd1;
        maddr = head_i.address; mdata = m - 8'd1;
      end
      OP_INC: begin
        nz_en = 1'b1; nz_val = m + 8'd1;
        maddr = head_i.address; mdata = m + 8'd1;
      end
      OP_DEX: begin
        x_d = x_q - 8'd1; nz_en = 1'b1; nz_val = x_q - 8'd1;
      end
      OP_DEY: begin
        y_d = y_q - 8'd1; nz_en = 1'b1; nz_val = y_q - 8'd1;
      end
      OP_INX: begin
        x_d = x_q + 8'd1; nz_en = 1'b1; nz_val = x_q + 8'd1;
      end
      OP_INY: begin
        y_d = y_q + 8'd1; nz_en = 1'b1; nz_val = y_q + 8'd1;
      end
      OP_LDA: begin
        a_d = m; nz_en = 1'b1; nz_val = m;
      end
      OP_LDX: begin
        x_d = m; nz_en = 1'b1; nz_val = m;
      end
      OP_LDY: begin
        y_d = m; nz_en = 1'b1; nz_val = m;
      end
      OP_PHA: begin
        maddr = {STACK_PAGE, sp_q}; mdata = a_q; sp_d = sp_q - 8'd1;
      end
      OP_PHP: begin
        maddr = {STACK_PAGE, sp_q}; mdata = f_d | PUSH_BITS; sp_d = sp_q - 8'd1;
      end
      OP_PLA: begin
        sp_d  = sp_q + 8'd1;
        maddr = {STACK_PAGE, sp_q + 8'd1};
        a_d   = m; nz_en = 1'b1; nz_val = m;
      end
      OP_PLP: begin
        sp_d       = sp_q + 8'd1;
        maddr      = {STACK_PAGE, sp_q + 8'd1};
        pend_vld_d = 1'b1;
        pend_val_d = m[FlagI];
        // The pulled I bit waits one instruction; the current I stays.
        f_d        = (m & PULL_MASK) | UNUSED_BIT;
        f_d[FlagI] = pend_vld_q ? pend_val_q : f_q[FlagI];
      end
      OP_STA: begin
        maddr = head_i.address; mdata = a_q;
      end
      OP_STX: begin
        maddr = head_i.address; mdata = x_q;
      end
      OP_STY: begin
        maddr = head_i.address; mdata = y_q;
      end
      OP_TAX: begin
        x_d = a_q; nz_en = 1'b1; nz_val = a_q;
      end
      OP_TAY: begin
        y_d = a_q; nz_en = 1'b1; nz_val = a_q;
      end
      OP_TSX: begin
        x_d = sp_q; nz_en = 1'b1; nz_val = sp_q;
      end
      OP_TXA: begin
        a_d = x_q; nz_en = 1'b1; nz_val = x_q;
      end
      OP_TYA: begin
        a_d = y_q; nz_en = 1'b1; nz_val = y_q;
      end
      OP_TXS: sp_d = x_q;
      default: ;
    endcase
    if (nz_en) begin
      f_d[FlagZ] = nz_val == 8'h00;
      f_d[FlagN] = nz_val[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q        <= '0;
      x_q        <= '0;
      y_q        <= '0;
      sp_q       <= SP_RESET;
      f_q        <= FLAGS_RESET;
      pend_vld_q <= 1'b0;
      pend_val_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (fire) begin
        a_q        <= a_d;
        x_q        <= x_d;
        y_q        <= y_d;
        sp_q       <= sp_d;
        f_q        <= f_d;
        pend_vld_q <= pend_vld_d;
        pend_val_q <= pend_val_d;
        out_vld_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {mdata, maddr, f_d, sp_d, y_d, x_d, a_d};
      out_user_q <= {head_i.stack_pull, head_i.mem_wr};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The unused status bit is always set and B never appears in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) f_q[FlagU] && !f_q[FlagB])
    else $error("status register lost the unused bit or holds B");

  // Only CLI, SEI and PLP leave a pending I change behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !(head_i.op == OP_CLI || head_i.op == OP_SEI || head_i.op == OP_PLP)
    |=> !pend_vld_q)
    else $error("pending I change survived an unrelated instruction");

  // An executed instruction always shows up at the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> out_vld_q)
    else $error("executed instruction did not reach the output register");

  // A word never reports a write and a stack pull at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_user_q[0] && out_user_q[1]))
    else $error("write and stack pull flagged together");

endmodule

// ----- hdl/cpu8_data_instruction_execute_top.sv -----
// Execute unit for the data instructions of an 8-bit 6502-style CPU in binary
// mode. Each input word carries one instruction (mnemonic index, the operand
// byte already fetched from memory or pulled from the stack, and the effective
// address); each output word gives A, X, Y, SP and the NV1BDIZC status byte
// after that instruction, plus the memory access it causes. The unit sustains
// one instruction per clock while the output side is not stalled: the only
// feedback loop is the update of the A/X/Y/SP/status registers in the execute
// stage. An accepted word is written into the instruction queue, executed from
// the queue head once it gets there and the output register is empty or being
// emptied, and captured in the output register, from which it is presented on
// the output. CLI, SEI and PLP change I only at the start of the following
// instruction, as the real part does. Stack addresses are on page one and SP
// wraps modulo 256.
module cpu8_data_instruction_execute_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input word fields from bit 0: opcode[5:0], operand[13:6], address[29:14],
  // zero fill[31:30].
  input  logic [cpu8ex_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Output word fields from bit 0: acc_out[7:0], x_out[15:8], y_out[23:16],
  // sp_out[31:24], flags_out[39:32], mem_addr[55:40], mem_data[63:56].
  output logic [cpu8ex_pkg::OUT_W-1:0]  m_axis_tdata_o,
  // Output side flags from bit 0: mem_write[0], mem_read_stack[1].
  output logic [cpu8ex_pkg::USER_W-1:0] m_axis_tuser_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);
  import cpu8ex_pkg::*;

  dec_t dec;
  dec_t head;
  logic head_valid;
  logic pop;

  // Front end: decode the mnemonic and classify its memory access.
  cpu8ex_front u_front (
    .tdata_i (s_axis_tdata_i),
    .dec_o   (dec)
  );

  // The queue lets the input side keep accepting words while the output
  // side is stalled, and the ready seen upstream is just "queue not full".
  cpu8ex_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid_i),
    .push_data_i  (dec),
    .push_ready_o (s_axis_tready_o),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // Back end: register file, ALU and the output register.
  cpu8ex_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- bench/cpu8ex_exec_checker.sv -----
`timescale 1ns / 1ps

// Watches both word channels of the execute unit, keeps its own copy of the
// CPU registers and predicts every retired word.
module cpu8ex_exec_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cpu8ex_pkg::IN_W-1:0]   instr_word_i,
  input  logic                          instr_valid_i,
  input  logic                          instr_ready_i,
  input  logic [cpu8ex_pkg::OUT_W-1:0]  retire_word_i,
  input  logic [cpu8ex_pkg::USER_W-1:0] retire_flags_i,
  input  logic                          retire_valid_i,
  input  logic                          retire_ready_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import cpu8ex_pkg::*;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic        wr;
    logic        rs;
    logic [15:0] maddr;
    logic [7:0]  mdata;
  } retire_t;

  logic [7:0] acc_r, x_r, y_r, sp_r, p_r;
  logic       i_pend_valid, i_pend_value;

  retire_t     retire_q[$];
  int unsigned errors;
  int unsigned reported;
  int unsigned words_out;

  function automatic void set_nz(input logic [7:0] v);
    p_r[FlagZ] = (v == 8'h00);
    p_r[FlagN] = v[7];
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    p_r[FlagC] = (r >= m);
    set_nz(r - m);
  endfunction

  function automatic retire_t retire_instr(input logic [5:0] opc, input logic [7:0] m,
                                           input logic [15:0] addr);
    retire_t    r;
    logic [8:0] sum;
    logic [7:0] addend;
    logic [7:0] t;
    r = '0;
    // A CLI, SEI or PLP from the previous instruction lands in I now.
    if (i_pend_valid) begin
      p_r[FlagI]   = i_pend_value;
      i_pend_valid = 1'b0;
    end
    case (opc)
      OP_ADC, OP_SBC: begin
        addend = (opc == OP_SBC) ? ~m : m;
        sum = {1'b0, acc_r} + {1'b0, addend} + {8'd0, p_r[FlagC]};
        p_r[FlagC] = sum[8];
        p_r[FlagV] = (acc_r[7] ^ sum[7]) & (addend[7] ^ sum[7]);
        acc_r = sum[7:0];
        set_nz(acc_r);
      end
      OP_AND: begin acc_r = acc_r & m; set_nz(acc_r); end
      OP_ORA: begin acc_r = acc_r | m; set_nz(acc_r); end
      OP_EOR: begin acc_r = acc_r ^ m; set_nz(acc_r); end
      OP_BIT: begin
        p_r[FlagZ] = ((acc_r & m) == 8'h00);
        p_r[FlagV] = m[6];
        p_r[FlagN] = m[7];
      end
      OP_CLC: p_r[FlagC] = 1'b0;
      OP_SEC: p_r[FlagC] = 1'b1;
      OP_CLD: p_r[FlagD] = 1'b0;
      OP_SED: p_r[FlagD] = 1'b1;
      OP_CLV: p_r[FlagV] = 1'b0;
      OP_CLI: begin i_pend_value = 1'b0; i_pend_valid = 1'b1; end
      OP_SEI: begin i_pend_value = 1'b1; i_pend_valid = 1'b1; end
      OP_CMP: compare_reg(acc_r, m);
      OP_CPX: compare_reg(x_r, m);
      OP_CPY: compare_reg(y_r, m);
      OP_DEC, OP_INC: begin
        t = (opc == OP_INC) ? m + 8'd1 : m - 8'd1;
        set_nz(t);
        r.wr = 1'b1; r.maddr = addr; r.mdata = t;
      end
      OP_DEX: begin x_r = x_r - 8'd1; set_nz(x_r); end
      OP_DEY: begin y_r = y_r - 8'd1; set_nz(y_r); end
      OP_INX: begin x_r = x_r + 8'd1; set_nz(x_r); end
      OP_INY: begin y_r = y_r + 8'd1; set_nz(y_r); end
      OP_LDA: begin acc_r = m; set_nz(m); end
      OP_LDX: begin x_r = m; set_nz(m); end
      OP_LDY: begin y_r = m; set_nz(m); end
      OP_PHA, OP_PHP: begin
        r.wr = 1'b1;
        r.maddr = {STACK_PAGE, sp_r};
        r.mdata = (opc == OP_PHA) ? acc_r : (p_r | PUSH_BITS);
        sp_r = sp_r - 8'd1;
      end
      OP_PLA: begin
        sp_r = sp_r + 8'd1;
        r.rs = 1'b1; r.maddr = {STACK_PAGE, sp_r};
        acc_r = m; set_nz(m);
      end
      OP_PLP: begin
        sp_r = sp_r + 8'd1;
        r.rs = 1'b1; r.maddr = {STACK_PAGE, sp_r};
        // The pulled I waits one instruction; B is dropped, bit 5 forced.
        i_pend_value = m[FlagI];
        i_pend_valid = 1'b1;
        t = (m & PULL_MASK) | UNUSED_BIT;
        t[FlagI] = p_r[FlagI];
        p_r = t;
      end
      OP_STA: begin r.wr = 1'b1; r.maddr = addr; r.mdata = acc_r; end
      OP_STX: begin r.wr = 1'b1; r.maddr = addr; r.mdata = x_r; end
      OP_STY: begin r.wr = 1'b1; r.maddr = addr; r.mdata = y_r; end
      OP_TAX: begin x_r = acc_r; set_nz(x_r); end
      OP_TAY: begin y_r = acc_r; set_nz(y_r); end
      OP_TSX: begin x_r = sp_r; set_nz(x_r); end
      OP_TXA: begin acc_r = x_r; set_nz(acc_r); end
      OP_TYA: begin acc_r = y_r; set_nz(acc_r); end
      OP_TXS: sp_r = x_r;
      default: ;
    endcase
    r.acc = acc_r; r.x = x_r; r.y = y_r; r.sp = sp_r; r.flags = p_r;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t want;
    retire_t got;
    if (!rst_ni) begin
      acc_r = 8'h00; x_r = 8'h00; y_r = 8'h00;
      sp_r = SP_RESET; p_r = FLAGS_RESET;
      i_pend_valid = 1'b0; i_pend_value = 1'b0;
      retire_q.delete();
      errors = 0; reported = 0; words_out = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (retire_valid_i && retire_ready_i) begin
        got.acc   = retire_word_i[7:0];
        got.x     = retire_word_i[15:8];
        got.y     = retire_word_i[23:16];
        got.sp    = retire_word_i[31:24];
        got.flags = retire_word_i[39:32];
        got.maddr = retire_word_i[55:40];
        got.mdata = retire_word_i[63:56];
        got.wr    = retire_flags_i[0];
        got.rs    = retire_flags_i[1];
        if (retire_q.size() == 0) begin
          errors++;
          if (reported < 10)
            $display("word %0d: output with nothing outstanding", words_out);
          reported++;
        end else begin
          want = retire_q.pop_front();
          if (got.acc !== want.acc || got.x !== want.x || got.y !== want.y ||
              got.sp !== want.sp || got.flags !== want.flags || got.wr !== want.wr ||
              got.rs !== want.rs || got.maddr !== want.maddr ||
              got.mdata !== want.mdata) begin
            errors++;
            if (reported < 10) begin
              $display("word %0d exp: A=%h X=%h Y=%h SP=%h P=%h wr=%b rs=%b addr=%h data=%h",
                       words_out, want.acc, want.x, want.y, want.sp, want.flags,
                       want.wr, want.rs, want.maddr, want.mdata);
              $display("word %0d got: A=%h X=%h Y=%h SP=%h P=%h wr=%b rs=%b addr=%h data=%h",
                       words_out, got.acc, got.x, got.y, got.sp, got.flags,
                       got.wr, got.rs, got.maddr, got.mdata);
            end
            reported++;
          end
        end
        words_out++;
      end
      if (instr_valid_i && instr_ready_i)
        retire_q.push_back(retire_instr(instr_word_i[5:0], instr_word_i[13:6],
                                        instr_word_i[29:14]));
      fail_count_o <= errors;
      pending_o <= retire_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the 6502 data-instruction execute unit. The checker
// beside the block predicts each output word; this module only feeds
// instruction words, applies backpressure and decides the final outcome.
module tb_top;
  import cpu8ex_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal silence is the long receiver hold-off below.
  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned PressureHold  = 48;
  localparam int unsigned RandomWords   = 600;
  localparam int unsigned QuietFrom     = 500;
  localparam int unsigned DrainCycles   = 16;

  logic              clk_i;
  logic              rst_n        = 1'b0;
  logic [IN_W-1:0]   instr_word   = '0;
  logic              instr_valid  = 1'b0;
  logic              instr_ready;
  logic [OUT_W-1:0]  retire_word;
  logic [USER_W-1:0] retire_flags;
  logic              retire_valid;
  logic              retire_ready = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent     = 0;
  bit          quiet_phase    = 1'b0;

  cpu8_data_instruction_execute_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (instr_word),
    .s_axis_tvalid_i (instr_valid),
    .s_axis_tready_o (instr_ready),
    .m_axis_tdata_o  (retire_word),
    .m_axis_tuser_o  (retire_flags),
    .m_axis_tvalid_o (retire_valid),
    .m_axis_tready_i (retire_ready)
  );

  cpu8ex_exec_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .instr_word_i   (instr_word),
    .instr_valid_i  (instr_valid),
    .instr_ready_i  (instr_ready),
    .retire_word_i  (retire_word),
    .retire_flags_i (retire_flags),
    .retire_valid_i (retire_valid),
    .retire_ready_i (retire_ready),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one instruction word and returns at the falling edge after it has
  // been taken. It is always entered at a falling edge. Outside the quiet
  // phase a short idle burst may come first, so gaps land at random points
  // relative to the queue and execute stage. When no gap is taken, tvalid
  // simply stays high from the previous word.
  task automatic send_instr(input logic [5:0] opc, input logic [7:0] operand,
                            input logic [15:0] addr);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      instr_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    instr_word  <= {2'b00, addr, operand, opc};
    instr_valid <= 1'b1;
    @(posedge clk_i);
    while (!instr_ready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Output side backpressure. Once, after the traffic has settled, the
  // receiver holds off for a long stretch while the sender keeps offering,
  // so the instruction queue fills and the input stalls. Otherwise it stalls
  // in short random bursts, and not at all in the quiet phase at the end.
  initial begin
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    wait (rst_n);
    forever @(negedge clk_i) begin
      if (hold_left > 0) begin
        hold_left--;
        retire_ready <= 1'b0;
      end else if (!pressure_done && words_sent >= 120) begin
        pressure_done = 1'b1;
        hold_left     = PressureHold - 1;
        retire_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 2);
        retire_ready <= 1'b0;
      end else begin
        retire_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle in which a word moves on either side restarts the
  // count. Reaching the limit means the block has hung.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((instr_valid && instr_ready) || (retire_valid && retire_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("cpu8_data_instruction_execute_top: mismatch");
    $finish;
  end

  initial begin
    logic [5:0]  opc;
    logic [7:0]  operand;
    logic [15:0] addr;
    int unsigned sel;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed part: flag extremes of the adder, the delayed I update of
    // SEI, CLI and PLP, stack wrap at both ends of page one, INC and DEC
    // across the byte boundary, a store at the highest address and opcodes
    // with no mnemonic assigned.
    send_instr(OP_LDA, 8'h00, 16'h0000);   // Z set
    send_instr(OP_ADC, 8'hFF, 16'h0000);   // A = FF, N set
    send_instr(OP_ADC, 8'h80, 16'hFFFF);   // carry and signed overflow
    send_instr(OP_SBC, 8'hFF, 16'h0000);   // overflow through subtraction
    send_instr(OP_CMP, 8'h80, 16'h0000);   // equal compare
    send_instr(OP_BIT, 8'hC0, 16'h0000);   // V and N from the operand
    send_instr(OP_SEI, 8'h00, 16'h0000);
    send_instr(OP_CLI, 8'h00, 16'h0000);   // SEI lands here, CLI waits
    send_instr(OP_PHP, 8'h00, 16'h0000);   // pushes with B and bit 5 set
    send_instr(OP_PLP, 8'hFF, 16'h0000);   // I keeps its old value for now
    send_instr(OP_PHP, 8'h00, 16'h0000);   // pulled I is visible here
    send_instr(OP_PLP, 8'h00, 16'h0000);
    send_instr(OP_SED, 8'h00, 16'h0000);
    send_instr(OP_CLD, 8'h00, 16'h0000);
    send_instr(OP_LDX, 8'h00, 16'h0000);
    send_instr(OP_TXS, 8'h00, 16'h0000);   // SP = 00
    send_instr(OP_PHA, 8'h00, 16'h0000);   // push at 0100, SP wraps to FF
    send_instr(OP_PLA, 8'h7F, 16'h0000);   // pull wraps SP back to 00
    send_instr(OP_INC, 8'hFF, 16'hFFFF);   // wraps to zero
    send_instr(OP_DEC, 8'h00, 16'h0000);   // wraps to FF
    send_instr(OP_STY, 8'h00, 16'hFFFF);
    send_instr(6'd63, 8'hFF, 16'hFFFF);    // unassigned, behaves as NOP
    send_instr(6'd39, 8'h00, 16'h0000);    // unassigned, behaves as NOP
    send_instr(OP_DEX, 8'h00, 16'h0000);
    send_instr(OP_TSX, 8'h00, 16'h0000);

    // Random part. Operands and addresses lean toward their extremes; a few
    // unassigned opcodes are mixed in. The last stretch runs without idling.
    for (int i = 0; i < RandomWords; i++) begin
      quiet_phase = (i >= QuietFrom);
      if ($urandom_range(0, 99) < 3)
        opc = 6'($urandom_range(39, 63));
      else
        opc = 6'($urandom_range(0, 38));
      sel = $urandom_range(0, 7);
      case (sel)
        0:       operand = 8'h00;
        1:       operand = 8'hFF;
        2:       operand = 8'h80;
        3:       operand = 8'h7F;
        default: operand = 8'($urandom_range(0, 255));
      endcase
      sel = $urandom_range(0, 7);
      case (sel)
        0:       addr = 16'h0000;
        1:       addr = 16'hFFFF;
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      send_instr(opc, operand, addr);
    end
    instr_valid <= 1'b0;

    // Drain: every predicted word must come out, then a short settle window
    // catches any stray extra output.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("cpu8_data_instruction_execute_top: match");
    end else begin
      $display("cpu8_data_instruction_execute_top: mismatch");
    end
    $finish;
  end

endmodule
